// File: hdl/wsc_pkg.sv
// Package for the word sort by character sum block.
// Holds the item structs, action codes and sequencer states; no dependencies.
`default_nettype none
package wsc_pkg;
	localparam int MAX_CHARS_DEF = 256;
	localparam int MAX_WORDS_DEF = 128;
	localparam logic [7:0] SPACE_CODE = 8'd32;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_FINISH = 2'd1,
		ACT_READ = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_LONG = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_SORT_RDI,
		S_SORT_RDJ,
		S_SORT_CMP,
		S_SORT_WRJ,
		S_READ_W,
		S_READ_C,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid;
		logic [1:0] status;
		logic       last_byte;
	} out_item_t;
endpackage
`default_nettype wire

// File: hdl/word_sort_by_char_sum.sv
// Top level of the word sort by character sum block.
// A finish first scans the line for words and then sorts the word tables by key.
// The finish is bound by one shared comparator and word tables with one read and one write port.
// One item is in work at a time; reset clears control state, tables are undefined.
// Depends on wsc_pkg.
`default_nettype none
module word_sort_by_char_sum import wsc_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF,
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);
	localparam int CW = $clog2(MAX_CHARS);
	localparam int WW = $clog2(MAX_WORDS);
	localparam int KW = CW + 8;

	logic [7:0]    line_mem [MAX_CHARS];
	logic [CW-1:0] start_mem [MAX_WORDS];
	logic [CW-1:0] end_mem [MAX_WORDS];
	logic [KW-1:0] key_mem [MAX_WORDS];

	state_t state_q, state_d;
	logic [CW:0]   byte_count_q;
	logic [WW:0]   word_count_q;
	logic [1:0]    err_q;
	logic          done_q;
	logic [WW:0]   read_word_q;
	logic [CW:0]   read_pos_q;
	logic [CW:0]   idx_q;
	logic [WW:0]   i_q, j_q;
	logic          in_word_q, drop_q;
	logic [7:0]    prev_q, rd_char_q;
	logic [KW-1:0] ki_q, rd_key_q;
	logic [CW-1:0] si_q, ei_q, rd_s_q, rd_e_q;
	out_item_t     res_q;

	logic          take;
	logic          line_we, word_we;
	logic [CW-1:0] line_wa, line_ra;
	logic [WW-1:0] word_wa, word_ra;
	logic [CW-1:0] ws_d, we_d;
	logic [KW-1:0] wk_d;

	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (action_t'(in_data.action))
						ACT_FINISH: state_d = (err_q == ST_LONG) ? S_OUT : S_SCAN_RD;
						ACT_READ: state_d = (done_q && err_q == ST_OK &&
							read_word_q < word_count_q) ? S_READ_W : S_OUT;
						ACT_LOAD, ACT_NOP: state_d = S_OUT;
					endcase
				end
			end
			S_SCAN_RD: state_d = (idx_q >= byte_count_q) ? S_SORT_RDI : S_SCAN;
			S_SCAN: begin
				if (idx_q != 0 && prev_q == SPACE_CODE && rd_char_q == SPACE_CODE)
					state_d = S_OUT;
				else
					state_d = S_SCAN_RD;
			end
			S_SORT_RDI: state_d = (i_q >= word_count_q) ? S_OUT : S_SORT_RDJ;
			S_SORT_RDJ: state_d = (j_q >= word_count_q) ? S_SORT_RDI : S_SORT_CMP;
			S_SORT_CMP: state_d = (ki_q > rd_key_q) ? S_SORT_WRJ : S_SORT_RDJ;
			S_SORT_WRJ: state_d = S_SORT_RDJ;
			S_READ_W: state_d = S_READ_C;
			S_READ_C: state_d = S_OUT;
			S_OUT: state_d = out_stall ? S_OUT : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		line_we = 1'b0;
		line_wa = byte_count_q[CW-1:0];
		line_ra = idx_q[CW-1:0];
		word_we = 1'b0;
		word_wa = i_q[WW-1:0];
		word_ra = i_q[WW-1:0];
		ws_d = si_q;
		we_d = ei_q;
		wk_d = ki_q;
		if (state_q == S_IDLE && take && in_data.action == ACT_LOAD) begin
			line_we = done_q || byte_count_q < (CW+1)'(MAX_CHARS);
			line_wa = done_q ? '0 : byte_count_q[CW-1:0];
		end
		unique case (state_q)
			S_SCAN: begin
				if (rd_char_q != SPACE_CODE && !drop_q) begin
					if (!in_word_q) begin
						if (word_count_q < (WW+1)'(MAX_WORDS)) begin
							word_we = 1'b1;
							word_wa = word_count_q[WW-1:0];
							ws_d = idx_q[CW-1:0];
							we_d = idx_q[CW-1:0];
							wk_d = KW'(rd_char_q);
						end
					end else begin
						word_we = 1'b1;
						word_wa = WW'(word_count_q - 1'b1);
						ws_d = si_q;
						we_d = idx_q[CW-1:0];
						wk_d = ki_q + KW'(rd_char_q);
					end
				end
			end
			S_SORT_RDJ: word_ra = j_q[WW-1:0];
			S_SORT_CMP: begin
				if (ki_q > rd_key_q) begin
					word_we = 1'b1;
					word_wa = i_q[WW-1:0];
					ws_d = rd_s_q;
					we_d = rd_e_q;
					wk_d = rd_key_q;
				end
			end
			S_SORT_WRJ: begin
				word_we = 1'b1;
				word_wa = WW'(j_q - 1'b1);
				ws_d = rd_s_q;
				we_d = rd_e_q;
				wk_d = rd_key_q;
			end
			S_READ_W: begin
				line_ra = rd_s_q + read_pos_q[CW-1:0];
				word_ra = read_word_q[WW-1:0];
			end
			S_IDLE: word_ra = read_word_q[WW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (line_we)
			line_mem[line_wa] <= in_data.char_in;
		rd_char_q <= line_mem[line_ra];
	end

	always_ff @(posedge clk) begin
		if (word_we) begin
			start_mem[word_wa] <= ws_d;
			end_mem[word_wa] <= we_d;
			key_mem[word_wa] <= wk_d;
		end
		rd_s_q <= start_mem[word_ra];
		rd_e_q <= end_mem[word_ra];
		rd_key_q <= key_mem[word_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			byte_count_q <= '0;
			word_count_q <= '0;
			err_q <= ST_OK;
			done_q <= 1'b0;
			read_word_q <= '0;
			read_pos_q <= '0;
			idx_q <= '0;
			i_q <= '0;
			j_q <= '0;
			in_word_q <= 1'b0;
			drop_q <= 1'b0;
			prev_q <= '0;
			ki_q <= '0;
			si_q <= '0;
			ei_q <= '0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						res_q <= '0;
						res_q.status <= err_q;
						unique case (action_t'(in_data.action))
							ACT_LOAD: begin
								if (done_q) begin
									byte_count_q <= (CW+1)'(1);
									word_count_q <= '0;
									err_q <= ST_OK;
									res_q.status <= ST_OK;
									read_word_q <= '0;
									read_pos_q <= '0;
									done_q <= 1'b0;
								end else if (byte_count_q < (CW+1)'(MAX_CHARS)) begin
									byte_count_q <= byte_count_q + 1'b1;
								end else begin
									err_q <= ST_LONG;
									res_q.status <= ST_LONG;
								end
							end
							ACT_FINISH: begin
								done_q <= 1'b1;
								word_count_q <= '0;
								read_word_q <= '0;
								read_pos_q <= '0;
								idx_q <= '0;
								i_q <= '0;
								in_word_q <= 1'b0;
								drop_q <= 1'b0;
							end
							ACT_READ, ACT_NOP: ;
						endcase
					end
				end
				S_SCAN_RD: begin
					if (idx_q >= byte_count_q) begin
						err_q <= ST_OK;
						i_q <= '0;
					end
				end
				S_SCAN: begin
					prev_q <= rd_char_q;
					idx_q <= idx_q + 1'b1;
					if (idx_q != 0 && prev_q == SPACE_CODE && rd_char_q == SPACE_CODE) begin
						err_q <= ST_DOUBLE;
						word_count_q <= '0;
						res_q.status <= ST_DOUBLE;
					end else if (rd_char_q == SPACE_CODE) begin
						in_word_q <= 1'b0;
						drop_q <= 1'b0;
					end else if (!in_word_q) begin
						in_word_q <= 1'b1;
						if (word_count_q < (WW+1)'(MAX_WORDS)) begin
							word_count_q <= word_count_q + 1'b1;
							si_q <= idx_q[CW-1:0];
							ki_q <= KW'(rd_char_q);
						end else begin
							drop_q <= 1'b1;
						end
					end else if (!drop_q) begin
						ki_q <= ki_q + KW'(rd_char_q);
					end
				end
				S_SORT_RDI: begin
					j_q <= i_q;
					res_q.status <= ST_OK;
				end
				S_SORT_RDJ: begin
					if (j_q == i_q) begin
						ki_q <= rd_key_q;
						si_q <= rd_s_q;
						ei_q <= rd_e_q;
					end
					if (j_q >= word_count_q)
						i_q <= i_q + 1'b1;
				end
				S_SORT_CMP: begin
					j_q <= j_q + 1'b1;
					if (ki_q > rd_key_q) begin
						ki_q <= rd_key_q;
						si_q <= rd_s_q;
						ei_q <= rd_e_q;
					end
				end
				S_SORT_WRJ: ;
				S_READ_W: ;
				S_READ_C: begin
					res_q.out_valid <= 1'b1;
					if (read_pos_q < (CW+1)'(rd_e_q - rd_s_q) + 1'b1) begin
						res_q.out_char <= rd_char_q;
						read_pos_q <= read_pos_q + 1'b1;
					end else begin
						res_q.out_char <= SPACE_CODE;
						res_q.last_byte <= (read_word_q + 1'b1 == word_count_q);
						read_word_q <= read_word_q + 1'b1;
						read_pos_q <= '0;
					end
				end
				S_OUT: ;
				default: ;
			endcase
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;
endmodule
`default_nettype wire

// File: hdl/wsc_checker.sv
// Port-level checker for word_sort_by_char_sum, with its bind.
// Depends on wsc_pkg.
`default_nettype none
module wsc_checker import wsc_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input accepted with a result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_byte |-> out_data.out_valid &&
		out_data.out_char == SPACE_CODE) else $error("bad last byte");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_valid |-> out_data.status == ST_OK)
		else $error("read byte with error status");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("no work after transfer");
endmodule

bind word_sort_by_char_sum wsc_checker u_wsc_checker (.*);
`default_nettype wire
